>>> src/sledd_pkg.sv
package sledd_pkg;

  // chain geometry
  localparam int NUM_LEDS = 16;
  localparam int LED_W = 5;
  localparam int BITS_PER_LED = 24;
  localparam int BIT_W = 5;
  localparam int TICK_W = 20;

  localparam logic [LED_W-1:0] LED_LAST = LED_W'(NUM_LEDS - 1);
  localparam logic [LED_W-1:0] LED_MAX = LED_W'(NUM_LEDS);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(BITS_PER_LED - 1);

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_ONE_HIGH = 2'd0,
    REG_ZERO_HIGH = 2'd1,
    REG_BIT_PERIOD = 2'd2,
    REG_LATCH_LOW = 2'd3
  } reg_idx_t;

  localparam logic [7:0] ONE_HIGH_RST = 8'd16;
  localparam logic [7:0] ZERO_HIGH_RST = 8'd8;
  localparam logic [7:0] BIT_PERIOD_RST = 8'd25;
  localparam logic [TICK_W-1:0] LATCH_LOW_RST = 20'd64000;

  // item function codes
  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK = 1'b1
  } func_t;

  // frame phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SEND = 3'b010,
    PH_LATCH = 3'b100
  } phase_t;

  typedef struct packed {
    logic func;
    logic [4:0] led_position;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic data_line;
    logic busy_res;
    logic frame_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0] one_high_ticks;
    logic [7:0] zero_high_ticks;
    logic [7:0] bit_period_ticks;
    logic [TICK_W-1:0] latch_low_ticks;
  } cfg_t;

endpackage

>>> src/single_led_strip_frame_driver.sv
// path: input register, then the core's step, then the result register
// throughput: one item per cycle; the input register and the result register
//   each advance whenever the next stage can take a beat
// reset: synchronous active-low rst_n clears valids and the frame sequencer to
//   idle with the line low, and loads the timing registers with their defaults
module single_led_strip_frame_driver
  import sledd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t cfg;
  logic s1_valid_r;
  in_item_t s1_item_r;
  logic out_valid_r;
  out_item_t out_res_r;
  out_item_t res;
  logic s1_adv;

  sledd_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  // stage advance and input handshake
  assign s1_adv = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  sledd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(s1_adv),
    .item   (s1_item_r),
    .cfg    (cfg),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_res_r;

endmodule

>>> src/sledd_cfg_regs.sv
module sledd_cfg_regs
  import sledd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  logic wr_en;
  reg_idx_t idx;

  assign idx = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg = cfg_r;

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_high_ticks <= ONE_HIGH_RST;
      cfg_r.zero_high_ticks <= ZERO_HIGH_RST;
      cfg_r.bit_period_ticks <= BIT_PERIOD_RST;
      cfg_r.latch_low_ticks <= LATCH_LOW_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_ONE_HIGH: cfg_r.one_high_ticks <= cfg_pwdata[7:0];
        REG_ZERO_HIGH: cfg_r.zero_high_ticks <= cfg_pwdata[7:0];
        REG_BIT_PERIOD: cfg_r.bit_period_ticks <= cfg_pwdata[7:0];
        REG_LATCH_LOW: cfg_r.latch_low_ticks <= cfg_pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      REG_ONE_HIGH: cfg_prdata = {24'd0, cfg_r.one_high_ticks};
      REG_ZERO_HIGH: cfg_prdata = {24'd0, cfg_r.zero_high_ticks};
      REG_BIT_PERIOD: cfg_prdata = {24'd0, cfg_r.bit_period_ticks};
      REG_LATCH_LOW: cfg_prdata = {12'd0, cfg_r.latch_low_ticks};
      default: cfg_prdata = '0;
    endcase
  end

endmodule

>>> src/sledd_core.sv
module sledd_core
  import sledd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  phase_t phase_r, phase_nxt;
  logic [LED_W-1:0] target_led_r, target_led_nxt;
  logic [23:0] colour_word_r, colour_word_nxt;
  logic [LED_W-1:0] led_cnt_r, led_cnt_nxt;
  logic [BIT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [TICK_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic line_r, line_nxt;

  logic [23:0] word;
  logic [BIT_W-1:0] bit_idx;
  logic bit_val;
  logic [7:0] high_ticks;
  logic [TICK_W-1:0] tick_inc;
  logic [LED_W-1:0] pos;
  logic done;

  // current bit of the chain
  assign word = (LED_W'(led_cnt_r + 1'b1) == target_led_r) ? colour_word_r : '0;
  assign bit_idx = BIT_LAST - bit_cnt_r;
  assign bit_val = word[bit_idx];
  assign high_ticks = bit_val ? cfg.one_high_ticks : cfg.zero_high_ticks;
  assign tick_inc = tick_cnt_r + 1'b1;

  // position clamp: zero means first led, beyond chain saturates
  always_comb begin
    pos = item.led_position;
    if (pos == '0) pos = LED_W'(1);
    if (pos > LED_MAX) pos = LED_MAX;
  end

  // one step of the frame sequencer
  always_comb begin
    phase_nxt = phase_r;
    target_led_nxt = target_led_r;
    colour_word_nxt = colour_word_r;
    led_cnt_nxt = led_cnt_r;
    bit_cnt_nxt = bit_cnt_r;
    tick_cnt_nxt = tick_cnt_r;
    line_nxt = line_r;
    done = 1'b0;
    if (item.func == FUNC_START) begin
      if (phase_r != PH_SEND && phase_r != PH_LATCH) begin
        target_led_nxt = pos;
        colour_word_nxt = {item.green, item.red, item.blue};
        led_cnt_nxt = '0;
        bit_cnt_nxt = '0;
        tick_cnt_nxt = '0;
        line_nxt = 1'b0;
        phase_nxt = PH_SEND;
      end
    end else begin
      unique case (phase_r)
        PH_SEND: begin
          line_nxt = (tick_cnt_r < {12'd0, high_ticks});
          tick_cnt_nxt = tick_inc;
          if (tick_inc >= {12'd0, cfg.bit_period_ticks}) begin
            tick_cnt_nxt = '0;
            if (bit_cnt_r == BIT_LAST) begin
              bit_cnt_nxt = '0;
              if (led_cnt_r == LED_LAST) begin
                led_cnt_nxt = '0;
                phase_nxt = PH_LATCH;
              end else begin
                led_cnt_nxt = led_cnt_r + 1'b1;
              end
            end else begin
              bit_cnt_nxt = bit_cnt_r + 1'b1;
            end
          end
        end
        PH_LATCH: begin
          line_nxt = 1'b0;
          tick_cnt_nxt = tick_inc;
          if (tick_inc >= cfg.latch_low_ticks) begin
            tick_cnt_nxt = '0;
            phase_nxt = PH_IDLE;
            done = 1'b1;
          end
        end
        default: begin
          line_nxt = 1'b0;
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  assign res.data_line = line_nxt;
  assign res.busy_res = (phase_nxt != PH_IDLE);
  assign res.frame_done = done;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      target_led_r <= '0;
      colour_word_r <= '0;
      led_cnt_r <= '0;
      bit_cnt_r <= '0;
      tick_cnt_r <= '0;
      line_r <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      target_led_r <= target_led_nxt;
      colour_word_r <= colour_word_nxt;
      led_cnt_r <= led_cnt_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      line_r <= line_nxt;
    end
  end

  // a finished frame always leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.frame_done |-> !res.busy_res)
    else $error("frame_done while still busy");

  // counters stay inside the frame while sending
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SEND |-> bit_cnt_r <= BIT_LAST && led_cnt_r <= LED_LAST)
    else $error("bit or led counter out of range");

  // line is only high during a frame, while sending or latching
  a_line_send: assert property (@(posedge clk) disable iff (!rst_n)
    line_r |-> phase_r == PH_SEND || phase_r == PH_LATCH)
    else $error("line high outside a frame");

  // target led is always a valid position once a frame starts
  a_target: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SEND |-> target_led_r != '0 && target_led_r <= LED_MAX)
    else $error("target led out of range");

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import sledd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned ITEM_BUDGET = 1650;
  localparam int unsigned RANDOM_PERIOD = 2;
  localparam int unsigned FRAME_ITEMS = NUM_LEDS * BITS_PER_LED * RANDOM_PERIOD;
  localparam int unsigned TAIL_CYCLES = 8;

  // idle styles for either side of the block
  localparam int unsigned GAP_NONE = 0;
  localparam int unsigned GAP_FULL = 1;
  localparam int unsigned GAP_SPARSE = 2;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  single_led_strip_frame_driver dut (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // strip state as the block should hold it
  cfg_t        timing = '{ONE_HIGH_RST, ZERO_HIGH_RST, BIT_PERIOD_RST, LATCH_LOW_RST};
  phase_t      strip_phase = PH_IDLE;
  logic [4:0]  lit_led = '0;
  logic [23:0] lit_colour = '0;
  logic [4:0]  led_idx = '0;
  logic [4:0]  bit_idx = '0;
  logic [19:0] tick_cnt = '0;
  logic        pin_level = 1'b0;

  out_item_t   pin_expected[$];
  int unsigned items_sent = 0;
  int unsigned frames_done = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned src_mode = GAP_SPARSE;
  int unsigned sink_mode = GAP_SPARSE;

  function automatic int unsigned draw_gap(input int unsigned mode);
    case (mode)
      GAP_FULL: return $urandom_range(0, 17);
      GAP_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
      default: return 0;
    endcase
  endfunction

  // advance the strip by one item and give the pin, busy and done it leaves
  function automatic out_item_t next_pin_state(input in_item_t it);
    out_item_t   res;
    logic [23:0] word;
    logic [7:0]  high_len;
    logic [4:0]  pos;
    res = '0;
    if (it.func == FUNC_START) begin
      // a command only takes effect while idle
      if (strip_phase == PH_IDLE) begin
        pos = it.led_position;
        if (pos == '0) pos = 5'd1;
        if (pos > LED_MAX) pos = LED_MAX;
        lit_led = pos;
        lit_colour = {it.green, it.red, it.blue};
        led_idx = '0;
        bit_idx = '0;
        tick_cnt = '0;
        pin_level = 1'b0;
        strip_phase = PH_SEND;
      end
    end else if (strip_phase == PH_SEND) begin
      // only the addressed led carries colour, msb first
      word = (led_idx + 5'd1 == lit_led) ? lit_colour : '0;
      high_len = word[BITS_PER_LED - 1 - bit_idx] ? timing.one_high_ticks
                                                   : timing.zero_high_ticks;
      pin_level = (tick_cnt < high_len);
      tick_cnt = tick_cnt + 20'd1;
      if (tick_cnt >= timing.bit_period_ticks) begin
        tick_cnt = '0;
        bit_idx = bit_idx + 5'd1;
        if (bit_idx >= BITS_PER_LED) begin
          bit_idx = '0;
          led_idx = led_idx + 5'd1;
          if (led_idx >= NUM_LEDS) begin
            led_idx = '0;
            strip_phase = PH_LATCH;
          end
        end
      end
    end else if (strip_phase == PH_LATCH) begin
      pin_level = 1'b0;
      tick_cnt = tick_cnt + 20'd1;
      if (tick_cnt >= timing.latch_low_ticks) begin
        tick_cnt = '0;
        strip_phase = PH_IDLE;
        res.frame_done = 1'b1;
        frames_done++;
      end
    end else begin
      pin_level = 1'b0;
    end
    res.data_line = pin_level;
    res.busy_res = (strip_phase != PH_IDLE);
    return res;
  endfunction

  // result side: after a beat, drop out_ready for a randomly drawn gap, which may be zero
  always @(posedge clk) begin : sink_side
    int unsigned gap;
    static int unsigned sink_wait = 0;
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait = 0;
    end else if (out_ready) begin
      if (out_valid) begin
        gap = draw_gap(sink_mode);
        if (gap != 0) begin
          out_ready <= 1'b0;
          sink_wait = gap;
        end
      end
    end else if (sink_wait > 1) begin
      sink_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare every result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pin_expected.size() == 0) begin
        $error("result beat with nothing expected: %b", out_data);
        mismatches++;
      end else begin
        want = pin_expected.pop_front();
        if (out_data.data_line !== want.data_line) begin
          $error("data_line: expected %0d, got %0d", want.data_line, out_data.data_line);
          mismatches++;
        end
        if (out_data.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_data.busy_res);
          mismatches++;
        end
        if (out_data.frame_done !== want.frame_done) begin
          $error("frame_done: expected %0d, got %0d", want.frame_done, out_data.frame_done);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one input beat, after a drawn gap; returns on the edge that takes it
  task automatic push_item(input in_item_t it);
    int unsigned gap;
    gap = draw_gap(src_mode);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pin_expected.push_back(next_pin_state(it));
    items_sent++;
  endtask

  function automatic in_item_t rand_item(input func_t fn);
    in_item_t it;
    it.func = fn;
    it.led_position = 5'($urandom_range(0, 31));
    it.green = 8'($urandom_range(0, 255));
    it.red = 8'($urandom_range(0, 255));
    it.blue = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t start_cmd(input logic [4:0] pos, input logic [7:0] g,
                                         input logic [7:0] r, input logic [7:0] b);
    in_item_t it;
    it.func = FUNC_START;
    it.led_position = pos;
    it.green = g;
    it.red = r;
    it.blue = b;
    return it;
  endfunction

  // stop sending and wait for every expected beat
  task automatic settle();
    in_valid <= 1'b0;
    while (pin_expected.size() != 0) @(posedge clk);
  endtask

  task automatic read_reg(input reg_idx_t idx);
    logic [CFG_DATA_W-1:0] want;
    case (idx)
      REG_ONE_HIGH: want = CFG_DATA_W'(timing.one_high_ticks);
      REG_ZERO_HIGH: want = CFG_DATA_W'(timing.zero_high_ticks);
      REG_BIT_PERIOD: want = CFG_DATA_W'(timing.bit_period_ticks);
      default: want = CFG_DATA_W'(timing.latch_low_ticks);
    endcase
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $error("%s: expected %0h, got %0h", idx.name(), want, cfg_prdata);
      mismatches++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_ONE_HIGH: timing.one_high_ticks = val[7:0];
      REG_ZERO_HIGH: timing.zero_high_ticks = val[7:0];
      REG_BIT_PERIOD: timing.bit_period_ticks = val[7:0];
      default: timing.latch_low_ticks = val[TICK_W-1:0];
    endcase
    read_reg(idx);
  endtask

  // only called with nothing in flight
  task automatic apply_timing(input int unsigned one_hi, input int unsigned zero_hi,
                              input int unsigned period, input int unsigned latch);
    settle();
    set_reg(REG_ONE_HIGH, CFG_DATA_W'(one_hi));
    set_reg(REG_ZERO_HIGH, CFG_DATA_W'(zero_hi));
    set_reg(REG_BIT_PERIOD, CFG_DATA_W'(period));
    set_reg(REG_LATCH_LOW, CFG_DATA_W'(latch));
  endtask

  // ticks until the latch period ends, with stray commands mixed in
  task automatic finish_frame(input int unsigned noise_pct);
    while (strip_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) push_item(rand_item(FUNC_START));
      else push_item(rand_item(FUNC_TICK));
    end
  endtask

  task automatic test_after_reset();
    read_reg(REG_ONE_HIGH);
    read_reg(REG_ZERO_HIGH);
    read_reg(REG_BIT_PERIOD);
    read_reg(REG_LATCH_LOW);
    // ticks while idle leave the line low
    push_item(start_cmd(5'h1F, 8'hFF, 8'hFF, 8'hFF) | in_item_t'({1'b1, 29'd0}));
    push_item(rand_item(FUNC_TICK));
    push_item(in_item_t'({1'b1, 29'd0}));
    settle();
  endtask

  task automatic test_positions();
    src_mode = GAP_SPARSE;
    sink_mode = GAP_SPARSE;
    // one bits high the whole period, zero bits high for one tick
    apply_timing(2, 1, 2, 4);
    // position zero lights the first led; busy command is dropped
    push_item(start_cmd(5'd0, 8'hFF, 8'h00, 8'h5A));
    push_item(rand_item(FUNC_TICK));
    push_item(rand_item(FUNC_TICK));
    push_item(start_cmd(5'h1F, 8'hFF, 8'hFF, 8'hFF));
    push_item(rand_item(FUNC_TICK));
    finish_frame(3);
    // idle ticks right behind the done beat
    src_mode = GAP_NONE;
    sink_mode = GAP_NONE;
    repeat (2) push_item(rand_item(FUNC_TICK));
  endtask

  task automatic test_register_limits();
    src_mode = GAP_FULL;
    sink_mode = GAP_FULL;
    apply_timing(255, 255, 255, (1 << TICK_W) - 1);
    repeat (4) push_item(rand_item(FUNC_TICK));
    apply_timing(1, 1, 2, 1);
    repeat (2) push_item(rand_item(FUNC_TICK));
  endtask

  function automatic int unsigned pick_high(input int unsigned period);
    case ($urandom_range(0, 4))
      0: return 1;
      1: return (period > 1) ? period - 1 : 1;
      2: return period;
      3: return $urandom_range(1, 255);
      default: return 255;
    endcase
  endfunction

  // frames with random timing and content until the item budget is spent
  task automatic test_random_frames();
    do begin
      src_mode = $urandom_range(GAP_NONE, GAP_SPARSE);
      sink_mode = $urandom_range(GAP_NONE, GAP_SPARSE);
      apply_timing(pick_high(RANDOM_PERIOD), pick_high(RANDOM_PERIOD), RANDOM_PERIOD,
                   ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 40));
      // a few idle ticks, then a frame with random content and stray commands
      repeat ($urandom_range(0, 3)) push_item(rand_item(FUNC_TICK));
      push_item(rand_item(FUNC_START));
      finish_frame($urandom_range(0, 10));
    end while (items_sent + FRAME_ITEMS <= ITEM_BUDGET);
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_positions();
    test_register_limits();
    test_random_frames();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
